>>> rtl/taun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taun_pkg
// Shared widths and pipeline payload types for the triangle normal unit.
// ----------------------------------------------------------------------------
package taun_pkg;

    localparam int CW     = 16;
    localparam int NCORN  = 9;
    localparam int INW    = CW * NCORN;
    localparam int EW     = 17;
    localparam int PW     = 34;
    localparam int MW     = 34;
    localparam int HW     = 17;
    localparam int SQW    = 67;
    localparam int SW     = 68;
    localparam int DETW   = 34;
    localparam int RW     = 38;
    localparam int DW     = 96;
    localparam int YW     = 84;
    localparam int TW     = 100;
    localparam int QW     = 15;
    localparam int NW     = 16;
    localparam int NCOMP  = 3;
    localparam int DSHIFT = 28;
    localparam int OUTW   = 88;

    typedef struct packed {
        logic [SW-1:0]               s;
        logic [RW-1:0]               rem;
        logic [DETW-1:0]             root;
        logic [NCOMP-1:0][SQW-1:0]   sq;
        logic [NCOMP-1:0]            neg;
    } sq_t;

    typedef struct packed {
        logic [SW-1:0]               s;
        logic [DETW-1:0]             det;
        logic [NCOMP-1:0][DW-1:0]    d;
        logic [NCOMP-1:0][YW-1:0]    y;
        logic [NCOMP-1:0][QW-1:0]    q;
        logic [NCOMP-1:0]            neg;
    } dv_t;

endpackage

>>> rtl/taun_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taun_front
// Edge vectors, cross product, magnitudes, squares and squared length.
// ----------------------------------------------------------------------------
module taun_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_v,
    input  logic [taun_pkg::INW-1:0] in_data,
    output logic                  out_v,
    output taun_pkg::sq_t         out_d
);
    import taun_pkg::*;

    logic [5:0] v_reg;
    logic [5:0] v_next;

    logic signed [CW-1:0] crn [NCORN];
    logic signed [EW-1:0] u_reg [NCOMP];
    logic signed [EW-1:0] w_reg [NCOMP];
    logic signed [EW-1:0] u_next [NCOMP];
    logic signed [EW-1:0] w_next [NCOMP];
    logic signed [PW-1:0] pa_reg [NCOMP];
    logic signed [PW-1:0] pb_reg [NCOMP];
    logic signed [PW-1:0] pa_next [NCOMP];
    logic signed [PW-1:0] pb_next [NCOMP];
    logic [PW:0]          pdiff [NCOMP];
    logic [PW:0]          pmag [NCOMP];
    logic [MW-1:0]        m_reg [NCOMP];
    logic [MW-1:0]        m_next [NCOMP];
    logic [NCOMP-1:0]     neg3_reg, neg4_reg, neg5_reg;
    logic [NCOMP-1:0]     neg3_next;
    logic [2*HW-1:0]      hh_reg [NCOMP];
    logic [2*HW-1:0]      hl_reg [NCOMP];
    logic [2*HW-1:0]      ll_reg [NCOMP];
    logic [2*HW-1:0]      hh_next [NCOMP];
    logic [2*HW-1:0]      hl_next [NCOMP];
    logic [2*HW-1:0]      ll_next [NCOMP];
    logic [SW-1:0]        sqsum [NCOMP];
    logic [SQW-1:0]       sq_reg [NCOMP];
    logic [SQW-1:0]       sq_next [NCOMP];
    sq_t                  out_reg;
    sq_t                  out_next;

    always_comb
    begin
        for (int i = 0; i < NCORN; i++)
        begin
            crn[i] = in_data[i*CW +: CW];
        end
        // u = b - a, w = c - a
        for (int k = 0; k < NCOMP; k++)
        begin
            u_next[k] = {crn[3+k][CW-1], crn[3+k]} - {crn[k][CW-1], crn[k]};
            w_next[k] = {crn[6+k][CW-1], crn[6+k]} - {crn[k][CW-1], crn[k]};
        end
        pa_next[0] = u_reg[1] * w_reg[2];
        pb_next[0] = u_reg[2] * w_reg[1];
        pa_next[1] = u_reg[2] * w_reg[0];
        pb_next[1] = u_reg[0] * w_reg[2];
        pa_next[2] = u_reg[0] * w_reg[1];
        pb_next[2] = u_reg[1] * w_reg[0];
        for (int k = 0; k < NCOMP; k++)
        begin
            pdiff[k]     = {pa_reg[k][PW-1], pa_reg[k]} - {pb_reg[k][PW-1], pb_reg[k]};
            neg3_next[k] = pdiff[k][PW];
            pmag[k]      = pdiff[k][PW] ? (~pdiff[k] + 1'b1) : pdiff[k];
            m_next[k]    = pmag[k][MW-1:0];
            hh_next[k]   = m_reg[k][MW-1:HW] * m_reg[k][MW-1:HW];
            hl_next[k]   = m_reg[k][MW-1:HW] * m_reg[k][HW-1:0];
            ll_next[k]   = m_reg[k][HW-1:0] * m_reg[k][HW-1:0];
            sqsum[k]     = {hh_reg[k], {(2*HW){1'b0}}}
                         + {{(SW-2*HW-HW-1){1'b0}}, hl_reg[k], {(HW+1){1'b0}}}
                         + {{(SW-2*HW){1'b0}}, ll_reg[k]};
            sq_next[k]   = sqsum[k][SQW-1:0];
        end
        out_next.s    = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        out_next.rem  = '0;
        out_next.root = '0;
        for (int k = 0; k < NCOMP; k++)
        begin
            out_next.sq[k] = sq_reg[k];
        end
        out_next.neg  = neg5_reg;
        v_next        = {v_reg[4:0], in_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            w_reg    <= w_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            m_reg    <= m_next;
            neg3_reg <= neg3_next;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            sq_reg   <= sq_next;
            out_reg  <= out_next;
        end
    end

    assign out_v = v_reg[5];
    assign out_d = out_reg;

endmodule

>>> rtl/taun_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taun_sqrt_cell
// One root bit of the restoring square root of the squared length.
// ----------------------------------------------------------------------------
module taun_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  taun_pkg::sq_t in_d,
    output logic          out_v,
    output taun_pkg::sq_t out_d
);
    import taun_pkg::*;

    logic          v_reg;
    sq_t           d_reg;
    sq_t           d_next;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          take;

    always_comb
    begin
        rem_sh = {in_d.rem[RW-3:0], in_d.s[2*BIT+1:2*BIT]};
        trial  = {{(RW-DETW-2){1'b0}}, in_d.root, 2'b01};
        take   = (rem_sh >= trial);
        d_next = in_d;
        d_next.rem  = take ? (rem_sh - trial) : rem_sh;
        d_next.root = {in_d.root[DETW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

>>> rtl/taun_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taun_div_cell
// One quotient bit of each normal component, q^2 * s <= m^2 * 2^28.
// ----------------------------------------------------------------------------
module taun_div_cell #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  taun_pkg::dv_t in_d,
    output logic          out_v,
    output taun_pkg::dv_t out_d
);
    import taun_pkg::*;

    logic          v_reg;
    dv_t           d_reg;
    dv_t           d_next;
    logic [TW-1:0] tval [NCOMP];
    logic [TW-1:0] dval [NCOMP];
    logic [TW-1:0] dsub [NCOMP];
    logic [YW-1:0] sadd;
    logic          take [NCOMP];

    always_comb
    begin
        d_next = in_d;
        sadd   = {{(YW-SW){1'b0}}, in_d.s} << BIT;
        for (int k = 0; k < NCOMP; k++)
        begin
            // step cost s * 2^b * (2q + 2^b), with y = s * q
            tval[k] = ({{(TW-YW){1'b0}}, in_d.y[k]} << (BIT + 1))
                    + ({{(TW-SW){1'b0}}, in_d.s} << (2 * BIT));
            dval[k] = {{(TW-DW){1'b0}}, in_d.d[k]};
            dsub[k] = dval[k] - tval[k];
            take[k] = (dval[k] >= tval[k]);
            if (take[k])
            begin
                d_next.d[k]      = dsub[k][DW-1:0];
                d_next.y[k]      = in_d.y[k] + sadd;
                d_next.q[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

>>> rtl/taun_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taun_out
// Result formatting, output register and skid stage with pipeline enable.
// ----------------------------------------------------------------------------
module taun_out (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_v,
    input  taun_pkg::dv_t              in_d,
    output logic                       en,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [taun_pkg::OUTW-1:0]  m_tdata,
    output logic                       m_tuser
);
    import taun_pkg::*;

    logic            out_valid_reg;
    logic            skid_valid_reg;
    logic [OUTW-1:0] out_data_reg;
    logic            out_user_reg;
    logic [OUTW-1:0] skid_data_reg;
    logic            skid_user_reg;
    logic [OUTW-1:0] res_data;
    logic            res_degen;
    logic [NW-1:0]   nrm [NCOMP];
    logic            pop;

    always_comb
    begin
        res_degen = (in_d.s == '0);
        for (int k = 0; k < NCOMP; k++)
        begin
            nrm[k] = in_d.neg[k] ? (NW'(0) - {1'b0, in_d.q[k]}) : {1'b0, in_d.q[k]};
            if (res_degen)
            begin
                nrm[k] = '0;
            end
        end
        res_data = {{(OUTW-DETW-NCOMP*NW){1'b0}}, nrm[2], nrm[1], nrm[0], in_d.det};
    end

    assign pop = out_valid_reg & m_tready;
    assign en  = ~skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_v)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (in_v)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_degen;
            end
            else
            begin
                out_data_reg <= res_data;
                out_user_reg <= res_degen;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/triangle_area_unit_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_area_unit_normal
// Cross product length and Q2.14 unit normal of a triangular face.
// ----------------------------------------------------------------------------
// usage
//   s_* takes one face per item: nine signed Q8.8 corner coordinates.
//   m_* returns det_len (floor length of the cross product, Q18.16), the
//   unit normal in Q2.14 truncated toward zero, and a degenerate flag in
//   m_tuser that is set when the cross product is zero (normal reads zero).
//   throughput: one item per cycle while s_tready is high, set by the fully pipelined chain.
//   pipeline: from accept to m_tvalid, items pass 6 front stages
//   (edges, products, magnitude, partial squares, squares, sum), 34 square
//   root cells (one root bit each), 15 normal cells (one quotient bit of
//   each component each) and the output register.
//   reset clears all valid flags; no item is in flight after reset.
//   a stalled receiver fills the output register, then the skid stage;
//   s_tready falls only when the skid stage holds an item, and the whole
//   chain then holds until the output register is taken.
// ----------------------------------------------------------------------------
module triangle_area_unit_normal (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz
    input  logic [taun_pkg::INW-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // det_len, norm_x, norm_y, norm_z, zero pad
    output logic [taun_pkg::OUTW-1:0]  m_tdata,
    // degenerate
    output logic                       m_tuser
);
    import taun_pkg::*;

    logic en;
    logic sq_v [DETW+1];
    sq_t  sq_d [DETW+1];
    logic dv_v [QW+1];
    dv_t  dv_d [QW+1];

    taun_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (s_tvalid),
        .in_data (s_tdata),
        .out_v   (sq_v[0]),
        .out_d   (sq_d[0])
    );

    for (genvar g = 0; g < DETW; g++)
    begin : g_sqrt
        taun_sqrt_cell #(.BIT(DETW - 1 - g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (sq_v[g]),
            .in_d  (sq_d[g]),
            .out_v (sq_v[g+1]),
            .out_d (sq_d[g+1])
        );
    end

    always_comb
    begin
        dv_v[0]     = sq_v[DETW];
        dv_d[0].s   = sq_d[DETW].s;
        dv_d[0].det = sq_d[DETW].root;
        dv_d[0].neg = sq_d[DETW].neg;
        for (int k = 0; k < NCOMP; k++)
        begin
            dv_d[0].d[k] = {{(DW-SQW-DSHIFT){1'b0}}, sq_d[DETW].sq[k], {DSHIFT{1'b0}}};
            dv_d[0].y[k] = '0;
            dv_d[0].q[k] = '0;
        end
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        taun_div_cell #(.BIT(QW - 1 - g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (dv_v[g]),
            .in_d  (dv_d[g]),
            .out_v (dv_v[g+1]),
            .out_d (dv_d[g+1])
        );
    end

    taun_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_v     (dv_v[QW]),
        .in_d     (dv_d[QW]),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign s_tready = en;

endmodule

>>> rtl/taun_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taun_checker
// Port level checks for the triangle normal unit.
// ----------------------------------------------------------------------------
module taun_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [taun_pkg::OUTW-1:0]  m_tdata,
    input logic                       m_tuser
);
    import taun_pkg::*;

    localparam int RESW = DETW + NCOMP * NW;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[RESW-1:0] == '0)
        else $error("degenerate item with nonzero fields");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[DETW-1:0] != '0)
        else $error("zero length without degenerate flag");

    a_ready_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind triangle_area_unit_normal taun_checker u_taun_checker (.*);
